// File: hdl/consecutive_prime_sum_counter_defines.svh
// Assertion macros for the consecutive prime sum counter.
`ifndef CONSECUTIVE_PRIME_SUM_COUNTER_DEFINES_SVH
`define CONSECUTIVE_PRIME_SUM_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
`define CPSC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CPSC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CPSC_ASSERT(label, clk, rst_n, prop)
`define CPSC_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: hdl/cpsc_pkg.sv
// Package: widths and shared types for the consecutive prime sum counter.
`timescale 1ns / 1ps
package cpsc_pkg;
  localparam int unsigned MaxTarget  = 65535;
  localparam int unsigned PrimeSlots = 8192;
  localparam int unsigned NumW       = 16;
  localparam int unsigned FlagAw     = 16;
  localparam int unsigned ListAw     = 13;
  localparam int unsigned CntW       = 14;
  localparam int unsigned SumW       = 17;
  localparam int unsigned WaysW      = 8;

  // classified job handed from front to back
  typedef struct packed {
    logic            skip;
    logic [NumW-1:0] target;
  } job_t;
endpackage

// File: hdl/consecutive_prime_sum_counter.sv
// Top level of the consecutive prime sum counter.
// One target in, one saturating count out. Each target runs a flag clear,
// the sieve strikes and a prime scan, then a window walk that adds primes
// at the tail and drops primes from the head. The sequencer makes one
// bitmap or prime list access per step and takes the next target only once
// the count has been taken. Targets above the maximum answer 0. No clearing
// pass at reset.
`timescale 1ns / 1ps
`include "consecutive_prime_sum_counter_defines.svh"
module consecutive_prime_sum_counter import cpsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [NumW-1:0]  target_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WaysW-1:0] ways_o
);
  logic job_valid, job_ready;
  job_t job;

  cpsc_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .target_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  cpsc_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .valid_o, .ready_i, .ways_o
  );

  `CPSC_ASSERT(a_out_hold, clk_i, rst_ni, valid_o && !ready_i |=> valid_o && $stable(ways_o))
  `CPSC_ASSERT(a_job_take, clk_i, rst_ni, job_valid && job_ready |=> !job_ready)
  `CPSC_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |-> !valid_o)
endmodule

// File: hdl/cpsc_front.sv
// Front end: accepts targets, flags out-of-range ones, two-entry queue.
`timescale 1ns / 1ps
module cpsc_front import cpsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [NumW-1:0] target_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output job_t            job_o
);
  job_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  job_t       in_job;

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign pop         = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_q];

  always_comb begin
    in_job.target = target_i;
    in_job.skip   = (32'(target_i) > MaxTarget);
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= in_job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hdl/cpsc_back.sv
// Back end: sieve, prime list gather and sliding-window sum sequencer.
`timescale 1ns / 1ps
module cpsc_back import cpsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  job_t             job_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WaysW-1:0] ways_o
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_INIT  = 11'b00000000010,
    S_JCHK  = 11'b00000000100,
    S_JRD   = 11'b00000001000,
    S_STRK  = 11'b00000010000,
    S_SCAN  = 11'b00000100000,
    S_SCANW = 11'b00001000000,
    S_RDT   = 11'b00010000000,
    S_ADDT  = 11'b00100000000,
    S_RDH   = 11'b01000000000,
    S_SUBH  = 11'b10000000000
  } state_e;

  state_e           state_q;
  logic [NumW-1:0]  n_q;
  logic [SumW-1:0]  j_q, i_q;
  logic [CntW-1:0]  cnt_q, head_q, tail_q;
  logic [SumW-1:0]  sum_q;
  logic [WaysW-1:0] ways_q;
  logic             out_v_q;
  logic [32:0]      jsq;

  logic             flags [MaxTarget+1];
  logic             flag_rd_q;
  logic [NumW-1:0]  plist [PrimeSlots];
  logic [NumW-1:0]  pl_rd_q;

  logic             f_we, f_wd;
  logic [FlagAw-1:0] f_wa, f_ra;
  logic             p_we;
  logic [ListAw-1:0] p_ra;

  assign jsq         = 33'(j_q) * 33'(j_q);
  assign job_ready_o = (state_q == S_IDLE) && !out_v_q;
  assign valid_o     = out_v_q;
  assign ways_o      = ways_q;

  // memory ports
  always_comb begin
    f_we = 1'b0; f_wd = 1'b0; f_wa = i_q[FlagAw-1:0];
    f_ra = j_q[FlagAw-1:0];
    p_we = 1'b0;
    p_ra = (state_q == S_RDH) ? head_q[ListAw-1:0] : tail_q[ListAw-1:0];
    unique case (state_q)
      S_INIT: begin f_we = 1'b1; f_wd = (i_q >= 17'd2); end
      S_STRK: begin f_we = (i_q <= 17'(n_q)); f_wd = 1'b0; end
      S_SCANW: p_we = flag_rd_q && (cnt_q < 14'(PrimeSlots)) && (j_q <= 17'(n_q));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (f_we) flags[f_wa] <= f_wd;
    flag_rd_q <= flags[f_ra];
    if (p_we) plist[cnt_q[ListAw-1:0]] <= j_q[NumW-1:0];
    pl_rd_q <= plist[p_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      n_q <= '0; j_q <= '0; i_q <= '0; cnt_q <= '0;
      head_q <= '0; tail_q <= '0; sum_q <= '0; ways_q <= '0;
    end else begin
      if (valid_o && ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (job_valid_i && job_ready_o) begin
          if (job_i.skip) begin
            ways_q <= '0; out_v_q <= 1'b1;
          end else begin
            n_q <= job_i.target; i_q <= '0; state_q <= S_INIT;
          end
        end
        S_INIT: begin
          if (i_q == 17'(n_q)) begin j_q <= 17'd2; state_q <= S_JCHK; end
          else i_q <= i_q + 17'd1;
        end
        S_JCHK: begin
          if (jsq > 33'(n_q)) begin
            j_q <= 17'd2; cnt_q <= '0; state_q <= S_SCAN;
          end else state_q <= S_JRD;
        end
        S_JRD: begin
          if (flag_rd_q) begin i_q <= jsq[SumW-1:0]; state_q <= S_STRK; end
          else begin j_q <= j_q + 17'd1; state_q <= S_JCHK; end
        end
        S_STRK: begin
          if (i_q > 17'(n_q)) begin j_q <= j_q + 17'd1; state_q <= S_JCHK; end
          else i_q <= i_q + j_q;
        end
        S_SCAN: state_q <= S_SCANW; // flag read in flight
        S_SCANW: begin
          if (j_q > 17'(n_q)) begin
            sum_q <= '0; head_q <= '0; tail_q <= '0; ways_q <= '0;
            state_q <= S_RDT;
          end else begin
            if (p_we) cnt_q <= cnt_q + 14'd1;
            j_q <= j_q + 17'd1; state_q <= S_SCAN;
          end
        end
        // window walk: grow tail while sum<=n, count matches, shrink head
        S_RDT: begin
          if (sum_q == 17'(n_q) && ways_q != 8'hFF) ways_q <= ways_q + 8'd1;
          if (tail_q >= cnt_q) begin out_v_q <= 1'b1; state_q <= S_IDLE; end
          else state_q <= S_ADDT;
        end
        S_ADDT: begin
          sum_q <= sum_q + 17'(pl_rd_q); tail_q <= tail_q + 14'd1;
          state_q <= S_RDH;
        end
        S_RDH: begin
          if (sum_q > 17'(n_q) && head_q < tail_q) state_q <= S_SUBH;
          else state_q <= S_RDT;
        end
        S_SUBH: begin
          sum_q <= sum_q - 17'(pl_rd_q); head_q <= head_q + 14'd1;
          state_q <= S_RDH;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/consecutive_prime_sum_counter_test.sv
// Testbench for the consecutive prime sum counter: table-driven and random targets vs. predictor.
`timescale 1ns / 1ps
module consecutive_prime_sum_counter_test;
  import cpsc_pkg::*;

  localparam int unsigned RandItems  = 100;
  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned HoldCycles = 20000;

  typedef struct {
    logic [NumW-1:0]  target;
    bit               typed;
    logic [WaysW-1:0] ways;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             valid_i;
  logic             ready_o;
  logic [NumW-1:0]  target_i;
  logic             valid_o;
  logic             ready_i;
  logic [WaysW-1:0] ways_o;

  logic [WaysW-1:0] ways_expected_q[$];
  logic [WaysW-1:0] typed_ways_q[$];
  bit               typed_flag_q[$];
  int unsigned      err_cnt;
  int unsigned      cycle_cnt;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  bit               hold_go;
  bit               hold_done;
  int unsigned      hold_left;
  bit               flags[0:MaxTarget];
  int unsigned      plist[PrimeSlots];

  consecutive_prime_sum_counter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .target_i(target_i),
    .valid_o (valid_o),
    .ready_i (ready_i),
    .ways_o  (ways_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sieve, prime list and two-pointer window walk, count saturating at 255
  function automatic logic [WaysW-1:0] count_prime_runs(int unsigned n);
    int unsigned j, i, cnt, sum, head, tail, ways;
    for (i = 0; i <= n; i++) flags[i] = 1'b1;
    flags[0] = 1'b0;
    if (n >= 1) flags[1] = 1'b0;
    for (j = 2; j * j <= n; j++) begin
      if (flags[j]) begin
        for (i = j * j; i <= n; i += j) flags[i] = 1'b0;
      end
    end
    cnt = 0;
    for (j = 2; j <= n; j++) begin
      if (flags[j] && cnt < PrimeSlots) begin
        plist[cnt] = j;
        cnt++;
      end
    end
    ways = 0;
    sum  = 0;
    head = 0;
    tail = cnt;
    for (i = 0; i < cnt; i++) begin
      sum += plist[i];
      if (sum > n) begin
        sum -= plist[i];
        tail = i;
        break;
      end
    end
    forever begin
      if (sum == n && ways < 255) ways++;
      if (tail >= cnt) break;
      sum += plist[tail];
      tail++;
      while (sum > n && head < tail) begin
        sum -= plist[head];
        head++;
      end
    end
    return ways[WaysW-1:0];
  endfunction

  task automatic offer_target(logic [NumW-1:0] t, bit typed, logic [WaysW-1:0] w);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    target_i <= t;
    typed_flag_q = {typed_flag_q, typed};
    typed_ways_q = {typed_ways_q, w};
    forever begin
      @(negedge clk_i);
      if (ready_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic drain_pending();
    valid_i <= 1'b0;
    while (ways_expected_q.size() != 0 || typed_flag_q.size() != 0) @(posedge clk_i);
  endtask

  // input side: stimulus
  initial begin
    stim_row_t   rows[$];
    logic [NumW-1:0] t;
    int unsigned k, r;
    valid_i   = 1'b0;
    target_i  = '0;
    rst_ni    = 1'b0;
    hold_go   = 1'b0;
    send_idle_pct  = 13;
    recv_stall_pct = 73;
    rows = '{
      '{16'd0,     1'b1, 8'd1},   // empty window matches zero
      '{16'd1,     1'b1, 8'd0},   // no primes at all
      '{16'd2,     1'b1, 8'd1},
      '{16'd3,     1'b1, 8'd1},
      '{16'd4,     1'b1, 8'd0},
      '{16'd5,     1'b1, 8'd2},
      '{16'd41,    1'b1, 8'd3},
      '{16'd17,    1'b0, 8'd0},
      '{16'd53,    1'b0, 8'd0},
      '{16'd963,   1'b0, 8'd0},
      '{16'd1000,  1'b0, 8'd0},
      '{16'd2,     1'b1, 8'd1},
      '{16'd65535, 1'b0, 8'd0},   // largest target, all bits set
      '{16'd32768, 1'b0, 8'd0},
      '{16'd0,     1'b1, 8'd1}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) offer_target(rows[k].target, rows[k].typed, rows[k].ways);
    drain_pending();
    hold_go = 1'b1;
    for (k = 0; k < RandItems; k++) begin
      if (k == RandItems / 3) begin
        send_idle_pct  = 73;
        recv_stall_pct = 13;
      end
      if (k == 2 * RandItems / 3) begin
        drain_pending();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 85) t = NumW'($urandom_range(600));
      else t = NumW'($urandom_range(3000, 601));
      offer_target(t, 1'b0, '0);
    end
    drain_pending();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // output side: ready with random stalls and one long hold-off
  initial begin
    ready_i   = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_i <= 1'b0;
      end else begin
        ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // transactions sampled mid-cycle, both sides stable then
  initial begin
    logic [WaysW-1:0] exp_w;
    bit               typed;
    err_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && valid_i && ready_o) begin
        typed = typed_flag_q.pop_front();
        exp_w = typed_ways_q.pop_front();
        if (!typed) exp_w = count_prime_runs(target_i);
        ways_expected_q = {ways_expected_q, exp_w};
      end
      if (rst_ni && valid_o && ready_i) begin
        if (ways_expected_q.size() == 0) begin
          $error("unexpected result: ways actual %0d", ways_o);
          err_cnt++;
        end else begin
          exp_w = ways_expected_q.pop_front();
          if (ways_o !== exp_w) begin
            $error("ways mismatch: expected %0d actual %0d", exp_w, ways_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/cpsc_pkg.sv
hdl/cpsc_front.sv
hdl/cpsc_back.sv
hdl/consecutive_prime_sum_counter.sv
tb/consecutive_prime_sum_counter_test.sv
